@@ sv/ldi_pkg.sv @@
// ----------------------------------------------------------------------------
// ldi_pkg
// shared widths, register indexes, result kinds and the item struct of the
// line deinterlacer
// ----------------------------------------------------------------------------
package ldi_pkg;

    // field widths
    localparam int PIX_W    = 8;
    localparam int ROW_W    = 12;
    localparam int COL_W    = 11;
    localparam int WIDTH_W  = 12;
    localparam int HEIGHT_W = 13;
    localparam int CFG_W    = 13;
    localparam int IDX_W    = 2;
    localparam int S_DATA_W = 8;
    localparam int S_USER_W = 1;
    localparam int M_DATA_W = 32;

    // limits of the register fields
    localparam int WIDTH_LIMIT  = 2048;
    localparam int HEIGHT_LIMIT = 4096;

    // configuration register indexes
    localparam logic [IDX_W-1:0] CFG_LINE_WIDTH   = 2'd0;
    localparam logic [IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [IDX_W-1:0] CFG_BLEND_MODE   = 2'd2;

    // reset values of the registers
    localparam logic [WIDTH_W-1:0]  RST_LINE_WIDTH   = 12'd640;
    localparam logic [HEIGHT_W-1:0] RST_FRAME_HEIGHT = 13'd480;
    localparam logic                RST_BLEND_MODE   = 1'b1;

    // what one input pixel produces
    localparam logic [1:0] KIND_NONE    = 2'd0;  // odd row dropped
    localparam logic [1:0] KIND_PIX     = 2'd1;  // pixel itself
    localparam logic [1:0] KIND_STORED  = 2'd2;  // stored pixel above
    localparam logic [1:0] KIND_AVG_PIX = 2'd3;  // average for row above, then pixel

    typedef logic [1:0] kind_t;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        kind_t            kind;
    } ldi_pos_t;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [PIX_W-1:0] pix;
        kind_t            kind;
    } ldi_item_t;

endpackage

@@ sv/ldi_line_store.sv @@
// ----------------------------------------------------------------------------
// ldi_line_store
// one-line pixel memory, read and write at the same address, old data out
// ----------------------------------------------------------------------------
module ldi_line_store #(
    parameter int DEPTH = 2048
) (
    input  logic                       aclk,
    input  logic                       en,
    input  logic                       we,
    input  logic [$clog2(DEPTH)-1:0]   addr,
    input  logic [ldi_pkg::PIX_W-1:0]  wdata,
    output logic [ldi_pkg::PIX_W-1:0]  rdata
);
    import ldi_pkg::*;

    logic [PIX_W-1:0] mem_reg [DEPTH];
    logic [PIX_W-1:0] rdata_reg;

    // read-before-write on a shared address
    always_ff @(posedge aclk) begin
        if (en) begin
            rdata_reg <= mem_reg[addr];
            if (we) begin
                mem_reg[addr] <= wdata;
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/ldi_pos_counter.sv @@
// ----------------------------------------------------------------------------
// ldi_pos_counter
// row and column counters, gives each accepted pixel its position and kind
// ----------------------------------------------------------------------------
module ldi_pos_counter (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          accept,
    input  logic                          frame_start,
    input  logic [ldi_pkg::WIDTH_W-1:0]   width,
    input  logic [ldi_pkg::HEIGHT_W-1:0]  height,
    input  logic                          blend,
    output ldi_pkg::ldi_pos_t             pos
);
    import ldi_pkg::*;

    logic [ROW_W-1:0]    row_reg, row_next;
    logic [COL_W-1:0]    col_reg, col_next;
    logic [ROW_W-1:0]    row_in;
    logic [COL_W-1:0]    col_in;
    logic [HEIGHT_W-1:0] row_adv;
    logic [ROW_W-1:0]    r;
    logic [COL_W-1:0]    c;
    logic [WIDTH_W-1:0]  c_inc;
    logic [HEIGHT_W-1:0] r_inc;

    always_comb begin
        row_in = frame_start ? '0 : row_reg;
        col_in = frame_start ? '0 : col_reg;

        // column past the width starts the next row
        if ({1'b0, col_in} >= width) begin
            c       = '0;
            row_adv = {1'b0, row_in} + 13'd1;
        end else begin
            c       = col_in;
            row_adv = {1'b0, row_in};
        end
        r = (row_adv >= height) ? '0 : row_adv[ROW_W-1:0];

        // counters after this pixel
        c_inc = {1'b0, c} + 12'd1;
        r_inc = {1'b0, r} + 13'd1;
        if (c_inc >= width) begin
            col_next = '0;
            row_next = (r_inc >= height) ? '0 : r_inc[ROW_W-1:0];
        end else begin
            col_next = c_inc[COL_W-1:0];
            row_next = r;
        end

        pos.row = r;
        pos.col = c;
        if (!r[0]) begin
            pos.kind = (blend && (r != '0)) ? KIND_AVG_PIX : KIND_PIX;
        end else if (!blend || ({1'b0, r} == height - 13'd1)) begin
            pos.kind = KIND_STORED;
        end else begin
            pos.kind = KIND_NONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg <= '0;
            col_reg <= '0;
        end else if (accept) begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

endmodule

@@ sv/ldi_result_stage.sv @@
// ----------------------------------------------------------------------------
// ldi_result_stage
// item register and result register, splits an item into one or two results
// ----------------------------------------------------------------------------
module ldi_result_stage (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        accept,
    input  ldi_pkg::ldi_item_t          item_in,
    input  logic [ldi_pkg::PIX_W-1:0]   rdata,
    output logic                        s_ready,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [ldi_pkg::ROW_W-1:0]   m_row,
    output logic [ldi_pkg::COL_W-1:0]   m_col,
    output logic [ldi_pkg::PIX_W-1:0]   m_value,
    output logic                        m_last
);
    import ldi_pkg::*;

    ldi_item_t        item_reg;
    logic             item_valid_reg;
    logic             phase_reg;
    logic             m_valid_reg;
    logic [ROW_W-1:0] m_row_reg;
    logic [COL_W-1:0] m_col_reg;
    logic [PIX_W-1:0] m_value_reg;
    logic             m_last_reg;

    logic             out_free;
    logic             pop;
    logic             is_final;
    logic [PIX_W:0]   sum;
    logic [ROW_W-1:0] res_row;
    logic [PIX_W-1:0] res_value;
    logic             res_last;

    assign out_free = !m_valid_reg || m_ready;
    assign pop      = item_valid_reg && out_free;
    assign is_final = (item_reg.kind != KIND_AVG_PIX) || phase_reg;
    assign s_ready  = !item_valid_reg || (pop && is_final);
    assign sum      = {1'b0, rdata} + {1'b0, item_reg.pix};

    always_comb begin
        res_row   = item_reg.row;
        res_value = item_reg.pix;
        res_last  = 1'b1;
        case (item_reg.kind)
            KIND_AVG_PIX: begin
                if (!phase_reg) begin
                    res_row   = item_reg.row - 12'd1;
                    res_value = sum[PIX_W:1];
                    res_last  = 1'b0;
                end
            end
            KIND_STORED: res_value = rdata;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
            phase_reg      <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (accept) begin
                item_valid_reg <= (item_in.kind != KIND_NONE);
                phase_reg      <= 1'b0;
            end else if (pop) begin
                if (is_final) begin
                    item_valid_reg <= 1'b0;
                end else begin
                    phase_reg <= 1'b1;
                end
            end
            if (pop) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= item_in;
        end
        if (pop) begin
            m_row_reg   <= res_row;
            m_col_reg   <= item_reg.col;
            m_value_reg <= res_value;
            m_last_reg  <= res_last;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_row   = m_row_reg;
    assign m_col   = m_col_reg;
    assign m_value = m_value_reg;
    assign m_last  = m_last_reg;

endmodule

@@ sv/line_deinterlacer_blend_or_copy.sv @@
// ----------------------------------------------------------------------------
// line_deinterlacer_blend_or_copy
// line-averaging deinterlacer: even rows pass and fill a line store, odd rows
// are rebuilt by copy or by the floor average of the rows around them
// ----------------------------------------------------------------------------
//
//  channel  direction  payload
//  s_       in         tdata: pixel [7:0]; tuser: frame_start
//  m_       out        tdata: out_row [11:0], out_column [22:12], out_value [30:23]
//                      tlast: last
//  cfg_     in         index 0 line_width, 1 frame_height, 2 blend_mode
//
//  a request is taken each cycle while the item register is empty or sends its
//  final result; an even row past row 0 in blend mode makes two results, everything
//  else one or none; a result passes the line store read and the item register, then
//  the result register
//  synchronous active-low reset clears counters and handshake state; the
//  line store has no reset and is valid only where written
//  a stalled result side holds the result register and the item register,
//  and the input side is held off once both are full
//
module line_deinterlacer_blend_or_copy #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [ldi_pkg::S_DATA_W-1:0]   s_tdata,   // pixel [7:0]
    input  logic [ldi_pkg::S_USER_W-1:0]   s_tuser,   // frame_start [0]
    // result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [ldi_pkg::M_DATA_W-1:0]   m_tdata,   // out_row, out_column, out_value, zero
    output logic                           m_tlast,
    // register writes
    input  logic                           cfg_we,
    input  logic [ldi_pkg::IDX_W-1:0]      cfg_index,
    input  logic [ldi_pkg::CFG_W-1:0]      cfg_data
);
    import ldi_pkg::*;

    // bounds from the build, limited to what the fields can express
    localparam int CAP_W = (MAX_WIDTH < WIDTH_LIMIT) ? MAX_WIDTH : WIDTH_LIMIT;
    localparam int CAP_H = (((MAX_HEIGHT < HEIGHT_LIMIT) ? MAX_HEIGHT : HEIGHT_LIMIT) / 2) * 2;
    localparam int AW    = $clog2(CAP_W);

    logic [WIDTH_W-1:0]  line_width_reg;
    logic [HEIGHT_W-1:0] frame_height_reg;
    logic                blend_mode_reg;

    logic [WIDTH_W-1:0]  use_width;
    logic [HEIGHT_W-1:0] use_height;
    logic [HEIGHT_W-1:0] h_capped;

    logic                accept;
    ldi_pos_t            pos;
    ldi_item_t           item;
    logic                store_we;
    logic [PIX_W-1:0]    rdata;
    logic [ROW_W-1:0]    out_row;
    logic [COL_W-1:0]    out_col;
    logic [PIX_W-1:0]    out_value;

    // register writes, indexes past the list are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_width_reg   <= RST_LINE_WIDTH;
            frame_height_reg <= RST_FRAME_HEIGHT;
            blend_mode_reg   <= RST_BLEND_MODE;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_LINE_WIDTH:   line_width_reg   <= cfg_data[WIDTH_W-1:0];
                CFG_FRAME_HEIGHT: frame_height_reg <= cfg_data[HEIGHT_W-1:0];
                CFG_BLEND_MODE:   blend_mode_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // width clamps to 1..cap, height clamps to cap, drops its low bit, min 2
    always_comb begin
        if (line_width_reg == '0) begin
            use_width = 12'd1;
        end else if (line_width_reg > WIDTH_W'(CAP_W)) begin
            use_width = WIDTH_W'(CAP_W);
        end else begin
            use_width = line_width_reg;
        end
        h_capped = (frame_height_reg > HEIGHT_W'(CAP_H)) ? HEIGHT_W'(CAP_H)
                                                         : frame_height_reg;
        h_capped[0] = 1'b0;
        use_height  = (h_capped < 13'd2) ? 13'd2 : h_capped;
    end

    assign accept = s_tvalid && s_tready;

    ldi_pos_counter u_pos (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .frame_start (s_tuser[0]),
        .width       (use_width),
        .height      (use_height),
        .blend       (blend_mode_reg),
        .pos         (pos)
    );

    // even rows are written into the store
    assign store_we = accept && ((pos.kind == KIND_PIX) || (pos.kind == KIND_AVG_PIX));

    ldi_line_store #(
        .DEPTH (CAP_W)
    ) u_store (
        .aclk  (aclk),
        .en    (accept),
        .we    (store_we),
        .addr  (pos.col[AW-1:0]),
        .wdata (s_tdata[PIX_W-1:0]),
        .rdata (rdata)
    );

    always_comb begin
        item.row  = pos.row;
        item.col  = pos.col;
        item.pix  = s_tdata[PIX_W-1:0];
        item.kind = pos.kind;
    end

    ldi_result_stage u_result (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .item_in (item),
        .rdata   (rdata),
        .s_ready (s_tready),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_row   (out_row),
        .m_col   (out_col),
        .m_value (out_value),
        .m_last  (m_tlast)
    );

    assign m_tdata = {1'b0, out_value, out_col, out_row};

endmodule
